// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the Kepler solver RTL.
// Clocked on clock and disabled while reset is high; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KENS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define KENS_ASSERT_NEVER(lbl, cond, msg) \
   `KENS_ASSERT(lbl, !(cond), msg)
`else
`define KENS_ASSERT(lbl, prop, msg)
`define KENS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/kens_pkg.sv =====
// Types, constants and helper functions of the Kepler equation solver.
// Used by the top level and the testbench; depends on nothing else.
package kens_pkg;

   localparam int Q32_WIDTH = 40;

   localparam logic signed [Q32_WIDTH-1:0] ONE_Q32     = 40'sd4294967296;
   localparam logic signed [Q32_WIDTH-1:0] GAIN_Q32    = 40'sd2608131496;
   localparam logic signed [Q32_WIDTH-1:0] PI_Q32      = 40'sd13493037704;
   localparam logic signed [Q32_WIDTH-1:0] TWO_PI_Q32  = 40'sd26986075409;
   localparam logic signed [Q32_WIDTH-1:0] HALF_PI_Q32 = 40'sd6746518852;

   localparam logic [6:0] ITER_LIMIT = 7'd64;

   localparam logic [15:0] TOLERANCE_RESET = 16'd1;
   localparam logic [6:0]  MAX_ITER_RESET  = 7'd32;

   typedef enum logic [0:0] {
      CSR_TOLERANCE = 1'b0,
      CSR_MAX_ITER  = 1'b1
   } csr_index_type;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_REDUCE = 10'b00_0000_0010,
      ST_FOLD   = 10'b00_0000_0100,
      ST_ROTATE = 10'b00_0000_1000,
      ST_MUL_S  = 10'b00_0001_0000,
      ST_MUL_C  = 10'b00_0010_0000,
      ST_SOLVE  = 10'b00_0100_0000,
      ST_DIVIDE = 10'b00_1000_0000,
      ST_UPDATE = 10'b01_0000_0000,
      ST_DONE   = 10'b10_0000_0000
   } state_type;

   function automatic logic signed [Q32_WIDTH-1:0] stage_atan(input logic [5:0] i);
      logic signed [Q32_WIDTH-1:0] v;
      v = '0;
      case (i)
         6'd0:    v = 40'sd3373259426;
         6'd1:    v = 40'sd1991351318;
         6'd2:    v = 40'sd1052175346;
         6'd3:    v = 40'sd534100635;
         6'd4:    v = 40'sd268086748;
         6'd5:    v = 40'sd134174063;
         6'd6:    v = 40'sd67103403;
         6'd7:    v = 40'sd33553749;
         6'd8:    v = 40'sd16777131;
         6'd9:    v = 40'sd8388597;
         6'd10:   v = 40'sd4194303;
         default: begin
            if (i <= 6'd32) begin
               v = 40'sd1 <<< (6'd32 - i);
            end
         end
      endcase
      return v;
   endfunction

   function automatic logic signed [33:0] clamp_unit(input logic signed [Q32_WIDTH-1:0] v);
      logic signed [33:0] r;
      if (v > ONE_Q32) begin
         r = 34'sd4294967296;
      end else if (v < -ONE_Q32) begin
         r = -34'sd4294967296;
      end else begin
         r = 34'(v);
      end
      return r;
   endfunction

   function automatic logic [32:0] unit_mag(input logic signed [33:0] v);
      logic signed [33:0] a;
      a = (v < 0) ? -v : v;
      return a[32:0];
   endfunction

   function automatic logic signed [34:0] ecc_round(input logic [64:0] p, input logic neg);
      logic [64:0] s;
      logic [34:0] m;
      s = p + 65'h0_8000_0000;
      m = {2'b00, s[64:32]};
      return neg ? -$signed(m) : $signed(m);
   endfunction

endpackage

// ===== hw/rtl/kens_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Uses no package items; instantiated by the solver top level.
module kens_divider #(
   parameter int NUMER_WIDTH = 65,
   parameter int DENOM_WIDTH = 34
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUMER_WIDTH-1:0] numer,
   input  logic [DENOM_WIDTH-1:0] denom,
   output logic                   done,
   output logic [NUMER_WIDTH-1:0] quot
);
   localparam int CNT_WIDTH = $clog2(NUMER_WIDTH + 1);

   logic [NUMER_WIDTH-1:0] qr_ff, qr_in;
   logic [DENOM_WIDTH-1:0] rem_ff, rem_in;
   logic [DENOM_WIDTH-1:0] den_ff, den_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [DENOM_WIDTH:0]   trial;
   logic [DENOM_WIDTH:0]   diff;
   logic                   fits;

   always_comb begin
      trial  = {rem_ff, qr_ff[NUMER_WIDTH-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = trial >= {1'b0, den_ff};
      qr_in  = qr_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         qr_in  = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CNT_WIDTH'(NUMER_WIDTH);
      end else if (cnt_ff != '0) begin
         qr_in   = {qr_ff[NUMER_WIDTH-2:0], fits};
         rem_in  = fits ? diff[DENOM_WIDTH-1:0] : trial[DENOM_WIDTH-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      qr_ff  <= qr_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = qr_ff;

endmodule

// ===== hw/rtl/kepler_equation_newton_solver_unit.sv =====
// Kepler equation solver: Newton iteration with a sequential CORDIC and divider.
// Each iteration runs range reduction, the fold, the CORDIC loop, the two multiplier
// states, the solve state and the bit-serial divider. The result register is loaded
// when the solver leaves ST_DONE with the output free, and a new request is taken
// only once the solver is back in ST_IDLE.
// Reset is synchronous; it idles the solver and loads the register reset values.
module kepler_equation_newton_solver_unit #(
   parameter int ANGLE_WIDTH   = 32,
   parameter int CORDIC_STAGES = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [ANGLE_WIDTH-1:0] req_mean_anomaly,
   input  logic [31:0]                   req_eccentricity,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ANGLE_WIDTH-1:0] rsp_solved_anomaly,
   output logic                          rsp_converged,
   output logic [6:0]                    rsp_iterations_used,
   input  logic                          csr_write_enable,
   input  kens_pkg::csr_index_type       csr_index,
   input  logic [15:0]                   csr_write_data
);
   import kens_pkg::*;
`include "assert_macros.svh"

   localparam int AW    = ANGLE_WIDTH;
   localparam int AF    = AW - 5;
   localparam int SH_L  = (AF < 32) ? 32 - AF : 0;
   localparam int SH_R  = (AF >= 32) ? AF - 32 : 0;
   localparam int AWL   = AW + SH_L;
   localparam int EWW   = 35 + SH_R;
   localparam int FW    = AW + 2;
   localparam int NW    = AW + 33;
   localparam int CW    = $clog2(CORDIC_STAGES);
   localparam logic signed [EWW-1:0] RND = EWW'((2 ** SH_L) / 2);
   localparam logic [NW-1:0] Q_LIMIT = NW'(1) << AW;
   localparam logic signed [AW+1:0] HI_EXT = {3'b000, {(AW-1){1'b1}}};
   localparam logic signed [AW+1:0] LO_EXT = {3'b111, {(AW-1){1'b0}}};

   state_type state_ff, state_in;
   logic signed [AW-1:0]        m_ff, m_in;
   logic [31:0]                 e_ff, e_in;
   logic signed [AW-1:0]        ea_ff, ea_in;
   logic signed [Q32_WIDTH-1:0] r_ff, r_in;
   logic signed [Q32_WIDTH-1:0] x_ff, x_in;
   logic signed [Q32_WIDTH-1:0] y_ff, y_in;
   logic                        flip_ff, flip_in;
   logic [CW-1:0]               stage_ff, stage_in;
   logic [64:0]                 prod_ff, prod_in;
   logic                        sin_neg_ff, sin_neg_in;
   logic                        cos_neg_ff, cos_neg_in;
   logic signed [34:0]          es_ff, es_in;
   logic                        f_neg_ff, f_neg_in;
   logic [6:0]                  iter_ff, iter_in;
   logic                        conv_ff, conv_in;
   logic [15:0]                 tol_ff;
   logic [6:0]                  maxit_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [AW-1:0]        rsp_ea_ff;
   logic                        rsp_conv_ff;
   logic [6:0]                  rsp_iter_ff;

   logic                        load_rsp;
   logic [6:0]                  cap;
   logic signed [Q32_WIDTH-1:0] rr;
   logic signed [Q32_WIDTH-1:0] x_shift, y_shift, atan_v;
   logic signed [33:0]          sin_c, cos_c;
   logic [32:0]                 mul_b;
   logic [64:0]                 mul_p;
   logic signed [34:0]          ec;
   logic signed [EWW-1:0]       es_wide;
   logic signed [FW-1:0]        es_ang, f_val;
   logic signed [FW-1:0]        f_abs;
   logic signed [34:0]          d_val;
   logic [NW-1:0]               numer;
   logic                        div_start, div_done;
   logic [NW-1:0]               quot;
   logic [AW:0]                 q_sat;
   logic signed [AW+1:0]        step, next_w, diff, adiff;
   logic signed [AW-1:0]        next_sat;
   logic signed [AWL-1:0]       ang_wide;
   logic signed [Q32_WIDTH-1:0] next_q32;
   logic                        hit;
   logic [6:0]                  iter_next;

   kens_divider #(
      .NUMER_WIDTH(NW),
      .DENOM_WIDTH(34)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(numer),
      .denom(d_val[33:0]),
      .done (div_done),
      .quot (quot)
   );

   always_comb begin
      cap = maxit_ff;
      if (maxit_ff == '0) begin
         cap = 7'd1;
      end else if (maxit_ff > ITER_LIMIT) begin
         cap = ITER_LIMIT;
      end

      rr = (r_ff >= PI_Q32) ? r_ff - TWO_PI_Q32 : r_ff;
      x_shift = x_ff >>> stage_ff;
      y_shift = y_ff >>> stage_ff;
      atan_v  = stage_atan(6'(stage_ff));
      sin_c   = clamp_unit(y_ff);
      cos_c   = clamp_unit(flip_ff ? -x_ff : x_ff);
      mul_b   = (state_ff == ST_MUL_S) ? unit_mag(sin_c) : unit_mag(cos_c);
      mul_p   = 65'(e_ff) * 65'(mul_b);

      ec      = ecc_round(prod_ff, cos_neg_ff);
      es_wide = ((EWW'(es_ff) + RND) >>> SH_L) <<< SH_R;
      es_ang  = FW'(es_wide);
      f_val   = FW'(ea_ff) - FW'(m_ff) - es_ang;
      f_abs   = (f_val < 0) ? -f_val : f_val;
      numer   = {f_abs[AW:0], 32'h0};
      d_val   = 35'sd4294967296 - ec;

      q_sat    = (quot > Q_LIMIT) ? Q_LIMIT[AW:0] : quot[AW:0];
      step     = f_neg_ff ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
      next_w   = (AW+2)'(ea_ff) - step;
      if (next_w > HI_EXT) begin
         next_sat = HI_EXT[AW-1:0];
      end else if (next_w < LO_EXT) begin
         next_sat = LO_EXT[AW-1:0];
      end else begin
         next_sat = next_w[AW-1:0];
      end
      diff      = (AW+2)'(next_sat) - (AW+2)'(ea_ff);
      adiff     = (diff < 0) ? -diff : diff;
      hit       = adiff <= $signed((AW+2)'(tol_ff));
      iter_next = iter_ff + 7'd1;
      ang_wide  = AWL'(next_sat) <<< SH_L;
      next_q32  = Q32_WIDTH'(ang_wide >>> SH_R);
   end

   always_comb begin
      state_in   = state_ff;
      m_in       = m_ff;
      e_in       = e_ff;
      ea_in      = ea_ff;
      r_in       = r_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      flip_in    = flip_ff;
      stage_in   = stage_ff;
      prod_in    = prod_ff;
      sin_neg_in = sin_neg_ff;
      cos_neg_in = cos_neg_ff;
      es_in      = es_ff;
      f_neg_in   = f_neg_ff;
      iter_in    = iter_ff;
      conv_in    = conv_ff;
      div_start  = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               m_in     = req_mean_anomaly;
               e_in     = req_eccentricity;
               ea_in    = '0;
               r_in     = '0;
               iter_in  = '0;
               conv_in  = 1'b0;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (r_ff < 0) begin
               r_in = r_ff + TWO_PI_Q32;
            end else if (r_ff >= TWO_PI_Q32) begin
               r_in = r_ff - TWO_PI_Q32;
            end else begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            flip_in = 1'b0;
            r_in    = rr;
            if (rr > HALF_PI_Q32) begin
               r_in    = PI_Q32 - rr;
               flip_in = 1'b1;
            end else if (rr < -HALF_PI_Q32) begin
               r_in    = -PI_Q32 - rr;
               flip_in = 1'b1;
            end
            x_in     = GAIN_Q32;
            y_in     = '0;
            stage_in = '0;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (r_ff >= 0) begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               r_in = r_ff - atan_v;
            end else begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               r_in = r_ff + atan_v;
            end
            if (stage_ff == CW'(CORDIC_STAGES - 1)) begin
               state_in = ST_MUL_S;
            end else begin
               stage_in = stage_ff + 1'b1;
            end
         end
         ST_MUL_S: begin
            prod_in    = mul_p;
            sin_neg_in = sin_c < 0;
            state_in   = ST_MUL_C;
         end
         ST_MUL_C: begin
            es_in      = ecc_round(prod_ff, sin_neg_ff);
            prod_in    = mul_p;
            cos_neg_in = cos_c < 0;
            state_in   = ST_SOLVE;
         end
         ST_SOLVE: begin
            f_neg_in  = f_val < 0;
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ea_in   = next_sat;
            iter_in = iter_next;
            conv_in = hit;
            if (hit || iter_next >= cap) begin
               state_in = ST_DONE;
            end else begin
               r_in     = next_q32;
               state_in = ST_REDUCE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || load_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= TOLERANCE_RESET;
         maxit_ff     <= MAX_ITER_RESET;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_TOLERANCE: tol_ff   <= csr_write_data;
               CSR_MAX_ITER:  maxit_ff <= csr_write_data[6:0];
               default:       tol_ff   <= tol_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff       <= m_in;
      e_ff       <= e_in;
      ea_ff      <= ea_in;
      r_ff       <= r_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      flip_ff    <= flip_in;
      stage_ff   <= stage_in;
      prod_ff    <= prod_in;
      sin_neg_ff <= sin_neg_in;
      cos_neg_ff <= cos_neg_in;
      es_ff      <= es_in;
      f_neg_ff   <= f_neg_in;
      conv_ff    <= conv_in;
      if (load_rsp) begin
         rsp_ea_ff   <= ea_ff;
         rsp_conv_ff <= conv_ff;
         rsp_iter_ff <= iter_ff;
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_solved_anomaly  = rsp_ea_ff;
   assign rsp_converged       = rsp_conv_ff;
   assign rsp_iterations_used = rsp_iter_ff;

   `KENS_ASSERT(a_accept_starts, req_valid && !req_stall |=> state_ff == ST_REDUCE, "start lost")
   `KENS_ASSERT_NEVER(a_iter_bound, iter_ff > ITER_LIMIT, "iteration count above limit")
   `KENS_ASSERT(a_rsp_count, $rose(rsp_valid) |-> (rsp_iterations_used != '0), "empty result")
   `KENS_ASSERT(a_div_start, div_start |=> state_ff == ST_DIVIDE && !div_done, "divider sequence")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Kepler equation Newton solver unit.
// Depends on kens_pkg and kepler_equation_newton_solver_unit; a built-in predictor
// computes each expected solution, and every response transfer is checked against it.
`timescale 1ns / 100ps

module testbench;
   import kens_pkg::*;

   typedef struct {
      logic signed [31:0] anomaly;
      logic               conv;
      logic [6:0]         iters;
   } solution_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_mean_anomaly = '0;
   logic [31:0]        req_eccentricity = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_solved_anomaly;
   logic               rsp_converged;
   logic [6:0]         rsp_iterations_used;
   logic               csr_write_enable = 1'b0;
   csr_index_type      csr_index = CSR_TOLERANCE;
   logic [15:0]        csr_write_data = '0;

   solution_type pending_solutions[$];
   longint unsigned tol_model;
   int unsigned     cap_model;
   int              error_count = 0;
   int              receiver_hold = 0;
   int              stall_left = 0;
   bit              busy_sides = 1'b1;

   kepler_equation_newton_solver_unit uut (.*);

   always #6 clock = ~clock;

   function automatic longint atan_step(int i);
      longint tbl [0:10] = '{64'd3373259426, 64'd1991351318, 64'd1052175346,
                             64'd534100635, 64'd268086748, 64'd134174063,
                             64'd67103403, 64'd33553749, 64'd16777131,
                             64'd8388597, 64'd4194303};
      if (i < 11) return tbl[i];
      if (i <= 32) return longint'(1) <<< (32 - i);
      return 0;
   endfunction

   function automatic longint unit_clamp(longint v);
      if (v > 64'sd4294967296) return 64'sd4294967296;
      if (v < -64'sd4294967296) return -64'sd4294967296;
      return v;
   endfunction

   function automatic void rotate_sin_cos(longint angle, output longint sn,
                                          output longint cs);
      longint r, x, y, t;
      bit flip;
      r = (angle <<< 5) % 64'sd26986075409;
      x = 64'sd2608131496;
      y = 0;
      flip = 1'b0;
      if (r < 0) r += 64'sd26986075409;
      if (r >= 64'sd13493037704) r -= 64'sd26986075409;
      if (r > 64'sd6746518852) begin
         r = 64'sd13493037704 - r;
         flip = 1'b1;
      end else if (r < -64'sd6746518852) begin
         r = -64'sd13493037704 - r;
         flip = 1'b1;
      end
      for (int i = 0; i < 30; i++) begin
         if (r >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            r -= atan_step(i);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            r += atan_step(i);
         end
         x = t;
      end
      sn = unit_clamp(y);
      cs = unit_clamp(flip ? -x : x);
   endfunction

   function automatic longint scale_by_ecc(longint unsigned e, longint v);
      longint unsigned mag, r;
      mag = (v < 0) ? longint'(-v) : v;
      r = (e * mag + 64'h8000_0000) >> 32;
      return (v < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint unsigned newton_quotient(longint unsigned n,
                                                      longint unsigned d);
      longint unsigned rem, q, b;
      rem = 0;
      q = 0;
      for (int k = 95; k >= 0; k--) begin
         b = (k >= 32) ? ((n >> (k - 32)) & 1) : 0;
         rem = (rem << 1) | b;
         q <<= 1;
         if (rem >= d) begin
            rem -= d;
            q |= 1;
         end
         if (q > 64'h1_0000_0000) return 64'h1_0000_0000;
      end
      return q;
   endfunction

   function automatic solution_type solve_kepler(logic signed [31:0] mean,
                                                 logic [31:0] ecc);
      solution_type s;
      longint m, ea, sn, cs, f, d, step, nxt, diff, fmag;
      longint unsigned q;
      int unsigned cap, n;
      bit conv;
      m = mean;
      ea = 0;
      n = 0;
      conv = 1'b0;
      cap = (cap_model == 0) ? 1 : (cap_model > 64) ? 64 : cap_model;
      while (n < cap) begin
         rotate_sin_cos(ea, sn, cs);
         f = ea - m - ((scale_by_ecc(ecc, sn) + 16) >>> 5);
         d = 64'sd4294967296 - scale_by_ecc(ecc, cs);
         fmag = (f < 0) ? -f : f;
         q = newton_quotient(fmag, d);
         step = (f < 0) ? -longint'(q) : longint'(q);
         nxt = ea - step;
         if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
         if (nxt < -64'sd2147483648) nxt = -64'sd2147483648;
         diff = nxt - ea;
         ea = nxt;
         n++;
         if (((diff < 0) ? -diff : diff) <= longint'(tol_model)) begin
            conv = 1'b1;
            break;
         end
      end
      s.anomaly = ea[31:0];
      s.conv = conv;
      s.iters = n[6:0];
      return s;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      solution_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_solutions.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_solved_anomaly, 0);
         end else begin
            want = pending_solutions.pop_front();
            if (rsp_solved_anomaly !== want.anomaly)
               report_mismatch("solved_anomaly", rsp_solved_anomaly, want.anomaly);
            if (rsp_converged !== want.conv)
               report_mismatch("converged", rsp_converged, want.conv);
            if (rsp_iterations_used !== want.iters)
               report_mismatch("iterations_used", rsp_iterations_used, want.iters);
         end
      end
   end

   always @(posedge clock) begin
      if (receiver_hold > 0) begin
         receiver_hold--;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = busy_sides ? $urandom_range(0, 6) : 0;
         rsp_stall <= (stall_left > 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= (stall_left > 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(logic signed [31:0] mean, logic [31:0] ecc);
      int gap;
      gap = busy_sides ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mean_anomaly <= mean;
      req_eccentricity <= ecc;
      do @(posedge clock); while (req_stall);
      pending_solutions.push_back(solve_kepler(mean, ecc));
   endtask

   task automatic drain;
      @(posedge clock);
      req_valid <= 1'b0;
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TOLERANCE) tol_model = value;
      else cap_model = value[6:0];
   endtask

   function automatic logic [31:0] random_ecc;
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 32'h0FFF_FFFF);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed;
      logic signed [31:0] means [0:4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1};
      logic [31:0] eccs [0:2] = '{0, 32'hFFFF_FFFF, 32'h8000_0000};
      foreach (means[i]) foreach (eccs[j]) send_item(means[i], eccs[j]);
      write_csr(CSR_MAX_ITER, 16'd0);
      send_item(32'sh1234_5678, 32'hC000_0000);
      write_csr(CSR_MAX_ITER, 16'hFFFF);
      send_item(32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(32'sh8000_0000, 32'hFFFF_FFF0);
      write_csr(CSR_TOLERANCE, 16'd0);
      send_item(32'sh1921_FB54, 32'h4000_0000);
      write_csr(CSR_TOLERANCE, 16'hFFFF);
      send_item(32'sh1921_FB54, 32'h4000_0000);
      send_item(-32'sh1921_FB54, 32'hF000_0000);
   endtask

   task automatic test_random(logic [15:0] tol, logic [15:0] cap, int count);
      write_csr(CSR_TOLERANCE, tol);
      write_csr(CSR_MAX_ITER, cap);
      for (int i = 0; i < count; i++) begin
         busy_sides = ((i / 40) % 4) != 3;
         send_item($urandom, random_ecc());
      end
      busy_sides = 1'b1;
   endtask

   task automatic test_backpressure;
      drain();
      receiver_hold = 15000;
      for (int i = 0; i < 6; i++) send_item($urandom, random_ecc());
   endtask

   task automatic test_pause_until_empty;
      for (int i = 0; i < 8; i++) begin
         send_item($urandom, random_ecc());
         if (i % 4 == 3) drain();
      end
   endtask

   initial begin
      tol_model = TOLERANCE_RESET;
      cap_model = MAX_ITER_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(16'd1, 16'd32, 330);
      test_random(16'd0, 16'd64, 330);
      test_random(16'hFFFF, 16'd1, 330);
      test_random(16'($urandom), 16'($urandom), 330);
      test_backpressure();
      test_pause_until_empty();
      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
